/* sv/bsfe_pkg.sv */
// ----------------------------------------------------------------------------
// bsfe_pkg
// Shared types and constants of the bitmap shape fill engine: command and
// result words, opcodes and the row mask control group.
// ----------------------------------------------------------------------------
package bsfe_pkg;

  localparam int OPC_W    = 3;
  localparam int ROW_IN_W = 4;
  localparam int COL_IN_W = 5;
  localparam int SQ_W     = 6;
  localparam int PR_W     = 2 * SQ_W;
  localparam int POS_W    = 8;
  localparam int RES_W    = 32;

  typedef enum logic [OPC_W-1:0] {
    OP_CLEAR   = 3'd0,
    OP_BOX     = 3'd1,
    OP_OUTLINE = 3'd2,
    OP_DISC    = 3'd3,
    OP_READ    = 3'd4
  } opcode_e;

  typedef logic signed [POS_W-1:0] pos_t;

  typedef struct packed {
    logic [OPC_W-1:0]    opcode;
    logic [ROW_IN_W-1:0] row_a;
    logic [COL_IN_W-1:0] col_a;
    logic [ROW_IN_W-1:0] row_b;
    logic [COL_IN_W-1:0] col_b;
    logic [SQ_W-1:0]     radius;
  } cmd_t;

  typedef struct packed {
    logic [RES_W-1:0] row_bits;
    logic             done_res;
  } res_t;

  typedef struct packed {
    logic                span_en;
    pos_t                lo;
    pos_t                hi;
    logic                pt_en;
    logic [COL_IN_W-1:0] pt_a;
    logic [COL_IN_W-1:0] pt_b;
  } mask_ctrl_t;

endpackage

/* sv/bitmap_shape_fill_engine.sv */
// ----------------------------------------------------------------------------
// bitmap_shape_fill_engine
// One-bit-per-cell bitmap with clear, box fill, outline, disc and row read
// commands. A sequencer sweeps the rows through a RAM; a shared 6x6 squarer
// serves the disc radius, row distance and integer square root steps.
// ----------------------------------------------------------------------------
// clear and unused opcodes answer from idle; read row reads, then answers;
//   box and outline read and write each row; disc squares the radius, then
//   per row: distance square, six shared-squarer root steps, read, write
// one command at a time; busy, if raised, stays high until the result strobe
// reset leaves the bitmap blank through per-row valid bits, no clearing pass
// results are shown for one cycle; the receiver cannot stall
// ----------------------------------------------------------------------------
module bitmap_shape_fill_engine #(
  parameter int ROWS = 16,
  parameter int COLS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  bsfe_pkg::cmd_t cmd_i,
  output logic           busy,
  output logic           res_valid_o,
  output bsfe_pkg::res_t res_o
);

  import bsfe_pkg::*;

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MULR,
    S_DX,
    S_SQRT,
    S_READ,
    S_WRITE,
    S_RDOUT
  } state_e;

  state_e            state_q;
  cmd_t              cmd_q;
  logic [RW-1:0]     row_q;
  logic              rd_ok_q;
  logic [ROWS-1:0]   valid_q;
  logic [PR_W-1:0]   r2_q;
  logic [PR_W-1:0]   rem_q;
  logic              disc_en_q;
  logic [SQ_W-1:0]   root_q;
  logic [2:0]        bit_q;
  logic              res_valid_q;
  res_t              res_q;

  pos_t              row_pos, ra_pos, rb_pos, ca_pos, cb_pos, dx, dx_mag;
  logic [SQ_W-1:0]   absdx, trial, mul_a;
  logic [PR_W-1:0]   prod;
  logic [PR_W:0]     diff;
  mask_ctrl_t        mctrl;
  logic [COLS-1:0]   mask;
  logic [COLS-1:0]   rdata, old_row, wdata;
  logic [RW-1:0]     raddr;
  logic              we;
  logic              last_row;
  logic [RES_W-1:0]  rd_low;

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign row_pos = pos_t'(row_q);
  assign ra_pos  = pos_t'(cmd_q.row_a);
  assign rb_pos  = pos_t'(cmd_q.row_b);
  assign ca_pos  = pos_t'(cmd_q.col_a);
  assign cb_pos  = pos_t'(cmd_q.col_b);

  // shared squarer
  assign dx     = row_pos - ra_pos;
  assign dx_mag = (dx < 0) ? -dx : dx;
  assign absdx  = dx_mag[SQ_W-1:0];
  assign trial  = root_q | (SQ_W'(1) << bit_q);

  always_comb begin
    case (state_q)
      S_MULR:  mul_a = cmd_q.radius;
      S_DX:    mul_a = absdx;
      default: mul_a = trial;
    endcase
  end

  assign prod = PR_W'(mul_a) * PR_W'(mul_a);
  assign diff = {1'b0, r2_q} - {1'b0, prod};

  // row mask control
  always_comb begin
    mctrl = '0;
    mctrl.pt_a = cmd_q.col_a;
    mctrl.pt_b = cmd_q.col_b;
    case (cmd_q.opcode)
      OP_BOX: begin
        mctrl.lo = (ca_pos < cb_pos) ? ca_pos : cb_pos;
        mctrl.hi = (ca_pos < cb_pos) ? cb_pos : ca_pos;
        mctrl.span_en = (ra_pos < rb_pos) ?
                        (row_pos >= ra_pos && row_pos <= rb_pos) :
                        (row_pos >= rb_pos && row_pos <= ra_pos);
      end
      OP_OUTLINE: begin
        mctrl.lo      = ca_pos;
        mctrl.hi      = cb_pos;
        mctrl.span_en = (row_pos == ra_pos) || (row_pos == rb_pos);
        mctrl.pt_en   = (row_pos >= ra_pos) && (row_pos <= rb_pos);
      end
      OP_DISC: begin
        mctrl.lo      = ca_pos - pos_t'(root_q);
        mctrl.hi      = ca_pos + pos_t'(root_q);
        mctrl.span_en = disc_en_q;
      end
      default: begin
        mctrl.span_en = 1'b0;
      end
    endcase
  end

  bsfe_row_mask #(
    .COLS (COLS)
  ) u_row_mask (
    .ctrl_i (mctrl),
    .mask_o (mask)
  );

  assign raddr    = (state_q == S_IDLE) ? RW'(cmd_i.row_a) : row_q;
  assign we       = (state_q == S_WRITE);
  assign old_row  = valid_q[row_q] ? rdata : '0;
  assign wdata    = old_row | mask;
  assign last_row = (row_q == RW'(ROWS - 1));

  bsfe_ram #(
    .WIDTH (COLS),
    .DEPTH (ROWS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (row_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  if (COLS >= RES_W) begin : g_wide
    assign rd_low = old_row[RES_W-1:0];
  end else begin : g_narrow
    assign rd_low = {{(RES_W - COLS){1'b0}}, old_row};
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      row_q       <= '0;
      rd_ok_q     <= 1'b0;
      valid_q     <= '0;
      r2_q        <= '0;
      rem_q       <= '0;
      disc_en_q   <= 1'b0;
      root_q      <= '0;
      bit_q       <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            cmd_q <= cmd_i;
            row_q <= '0;
            case (cmd_i.opcode)
              OP_CLEAR: begin
                valid_q     <= '0;
                res_valid_q <= 1'b1;
                res_q       <= '{row_bits: '0, done_res: 1'b1};
              end
              OP_BOX, OP_OUTLINE: begin
                state_q <= S_READ;
              end
              OP_DISC: begin
                state_q <= S_MULR;
              end
              OP_READ: begin
                row_q   <= RW'(cmd_i.row_a);
                rd_ok_q <= pos_t'(cmd_i.row_a) < pos_t'(ROWS);
                state_q <= S_RDOUT;
              end
              default: begin
                res_valid_q <= 1'b1;
                res_q       <= '{row_bits: '0, done_res: 1'b1};
              end
            endcase
          end
        end
        S_MULR: begin
          r2_q    <= prod;
          state_q <= S_DX;
        end
        S_DX: begin
          rem_q     <= diff[PR_W-1:0];
          disc_en_q <= !diff[PR_W];
          root_q    <= '0;
          bit_q     <= 3'(SQ_W - 1);
          state_q   <= S_SQRT;
        end
        S_SQRT: begin
          if (prod <= rem_q) begin
            root_q <= trial;
          end
          if (bit_q == '0) begin
            state_q <= S_READ;
          end else begin
            bit_q <= bit_q - 3'd1;
          end
        end
        S_READ: begin
          state_q <= S_WRITE;
        end
        S_WRITE: begin
          valid_q[row_q] <= 1'b1;
          if (last_row) begin
            res_valid_q <= 1'b1;
            res_q       <= '{row_bits: '0, done_res: 1'b1};
            state_q     <= S_IDLE;
          end else begin
            row_q   <= row_q + RW'(1);
            state_q <= (cmd_q.opcode == OP_DISC) ? S_DX : S_READ;
          end
        end
        S_RDOUT: begin
          res_valid_q <= 1'b1;
          res_q       <= '{row_bits: (rd_ok_q ? rd_low : '0), done_res: 1'b1};
          state_q     <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // clear answers in the next cycle
  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (cmd_i.opcode == OP_CLEAR) |=> res_valid_o)
    else $error("clear did not return a result word");

  // a result word never overlaps a running command
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("result word while busy");

  // root search stays within the bit range
  a_sqrt_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQRT) |-> (bit_q < 3'(SQ_W)))
    else $error("root step out of range");

  // only a read returns row bits
  a_bits_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.row_bits != '0) |-> (cmd_q.opcode == OP_READ))
    else $error("row bits on a non-read command");

  // a row write follows its read
  a_write_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |-> ($past(state_q) == S_READ))
    else $error("row write without read");

endmodule

/* sv/bsfe_ram.sv */
// ----------------------------------------------------------------------------
// bsfe_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bsfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* sv/bsfe_row_mask.sv */
// ----------------------------------------------------------------------------
// bsfe_row_mask
// Builds the set mask of one bitmap row: a column span plus up to two single
// columns, all columns evaluated in parallel.
// ----------------------------------------------------------------------------
module bsfe_row_mask #(
  parameter int COLS = 32
) (
  input  bsfe_pkg::mask_ctrl_t ctrl_i,
  output logic [COLS-1:0]      mask_o
);

  import bsfe_pkg::*;

  for (genvar j = 0; j < COLS; j++) begin : g_col
    localparam pos_t JP = pos_t'(j);
    logic in_span;
    logic on_pt;
    assign in_span = ctrl_i.span_en && (JP >= ctrl_i.lo) && (JP <= ctrl_i.hi);
    assign on_pt   = ctrl_i.pt_en &&
                     ((pos_t'(ctrl_i.pt_a) == JP) || (pos_t'(ctrl_i.pt_b) == JP));
    assign mask_o[j] = in_span || on_pt;
  end

endmodule

/* test/bitmap_shape_fill_engine_tb.sv */
// ----------------------------------------------------------------------------
// bitmap_shape_fill_engine_tb
// Self-checking testbench of the bitmap shape fill engine. Commands go in
// through the start/busy handshake; a bitmap predictor in the testbench
// tracks every clear, box, outline and disc. Each result word is compared
// with the oldest pending prediction. Directed corner cases come first,
// then random traffic with sender gaps, then back-to-back traffic.
// ----------------------------------------------------------------------------
module bitmap_shape_fill_engine_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import bsfe_pkg::*;

  localparam int ROWS         = 16;
  localparam int COLS         = 32;
  localparam int OPC_LAST     = (1 << OPC_W) - 1;
  localparam int MAX_RADIUS   = (1 << SQ_W) - 1;
  localparam int LAST_ROW     = (1 << ROW_IN_W) - 1;
  localparam int LAST_COL     = (1 << COL_IN_W) - 1;
  localparam int DRAIN_CYCLES = 2 + 9 * ROWS + 16;
  localparam int CYCLE_LIMIT  = 1_000_000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  cmd_t cmd_i;
  logic busy;
  logic res_valid_o;
  res_t res_o;

  logic [COLS-1:0] bitmap_rows [ROWS];
  res_t            expected_words [$];
  int              mismatch_count;
  int              cycle_count;
  bit              gaps_on;

  bitmap_shape_fill_engine #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .cmd_i      (cmd_i),
    .busy       (busy),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic cmd_t make_cmd(int op, int ra, int ca, int rb, int cb, int rad);
    cmd_t c;
    c.opcode = op[OPC_W-1:0];
    c.row_a  = ra[ROW_IN_W-1:0];
    c.col_a  = ca[COL_IN_W-1:0];
    c.row_b  = rb[ROW_IN_W-1:0];
    c.col_b  = cb[COL_IN_W-1:0];
    c.radius = rad[SQ_W-1:0];
    return c;
  endfunction

  function automatic void mark_cell(int r, int c);
    if (r >= 0 && r < ROWS && c >= 0 && c < COLS) bitmap_rows[r][c] = 1'b1;
  endfunction

  // updates the bitmap copy and returns the word the command should produce
  function automatic res_t draw_and_predict(cmd_t c);
    res_t w;
    int   ra, ca, rb, cb, rad, rlo, rhi, clo, chi, dr, dc;
    ra  = int'(c.row_a);
    ca  = int'(c.col_a);
    rb  = int'(c.row_b);
    cb  = int'(c.col_b);
    rad = int'(c.radius);
    w.row_bits = '0;
    w.done_res = 1'b1;
    case (c.opcode)
      OP_CLEAR: begin
        for (int i = 0; i < ROWS; i++) bitmap_rows[i] = '0;
      end
      OP_BOX: begin
        rlo = (ra < rb) ? ra : rb;
        rhi = (ra < rb) ? rb : ra;
        clo = (ca < cb) ? ca : cb;
        chi = (ca < cb) ? cb : ca;
        for (int i = rlo; i <= rhi; i++)
          for (int j = clo; j <= chi; j++) mark_cell(i, j);
      end
      OP_OUTLINE: begin
        for (int i = ra; i <= rb; i++) begin
          mark_cell(i, ca);
          mark_cell(i, cb);
        end
        for (int j = ca; j <= cb; j++) begin
          mark_cell(ra, j);
          mark_cell(rb, j);
        end
      end
      OP_DISC: begin
        for (int i = 0; i < ROWS; i++)
          for (int j = 0; j < COLS; j++) begin
            dr = i - ra;
            dc = j - ca;
            if (dr * dr + dc * dc <= rad * rad) bitmap_rows[i][j] = 1'b1;
          end
      end
      OP_READ: begin
        if (ra < ROWS) w.row_bits = RES_W'(bitmap_rows[ra]);
      end
      default: begin
      end
    endcase
    return w;
  endfunction

  function automatic cmd_t random_cmd();
    int   pick;
    int   op;
    cmd_t c;
    pick = $urandom_range(0, 99);
    if (pick < 4)       op = OP_CLEAR;
    else if (pick < 18) op = OP_BOX;
    else if (pick < 36) op = OP_OUTLINE;
    else if (pick < 48) op = OP_DISC;
    else if (pick < 94) op = OP_READ;
    else                op = $urandom_range(OP_READ + 1, OPC_LAST);
    c = make_cmd(op, $urandom, $urandom, $urandom, $urandom, $urandom);
    // keep most discs small so the bitmap does not saturate
    if (op == OP_DISC && $urandom_range(0, 7) != 0)
      c.radius = SQ_W'($urandom_range(0, 6));
    return c;
  endfunction

  task automatic send_cmd(cmd_t c);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    expected_words.push_back(draw_and_predict(c));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic report_mismatch(string what, logic [RES_W-1:0] exp_v, logic [RES_W-1:0] got_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %s: expected %h got %h at %0t", what, exp_v, got_v, $realtime);
  endtask

  always @(posedge clk_i) begin
    res_t exp_w;
    if (rst_ni && res_valid_o) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", '0, res_o.row_bits);
      end else begin
        exp_w = expected_words.pop_front();
        if (res_o.row_bits !== exp_w.row_bits)
          report_mismatch("row_bits", exp_w.row_bits, res_o.row_bits);
        if (res_o.done_res !== exp_w.done_res)
          report_mismatch("done_res", RES_W'(exp_w.done_res), RES_W'(res_o.done_res));
      end
    end
  end

  task automatic test_directed_cases();
    send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_BOX, 0, 0, LAST_ROW, LAST_COL, 0));
    send_cmd(make_cmd(OP_READ, LAST_ROW, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_CLEAR, LAST_ROW, LAST_COL, LAST_ROW, LAST_COL, MAX_RADIUS));
    send_cmd(make_cmd(OP_READ, 7, LAST_COL, LAST_ROW, LAST_COL, MAX_RADIUS));
    // corners given in reverse order on both axes
    send_cmd(make_cmd(OP_BOX, 12, 25, 3, 4, 0));
    send_cmd(make_cmd(OP_READ, 3, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_READ, 13, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_OUTLINE, 2, 3, 10, 20, 0));
    send_cmd(make_cmd(OP_READ, 5, 0, 0, 0, 0));
    // reversed rows: horizontal edges only
    send_cmd(make_cmd(OP_OUTLINE, 14, 22, 12, 30, 0));
    send_cmd(make_cmd(OP_READ, 14, 0, 0, 0, 0));
    // reversed columns: vertical edges only
    send_cmd(make_cmd(OP_OUTLINE, 11, 28, 15, 24, 0));
    send_cmd(make_cmd(OP_READ, 13, 0, 0, 0, 0));
    // both reversed: nothing drawn
    send_cmd(make_cmd(OP_OUTLINE, 1, 31, 0, 0, 0));
    send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_DISC, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_DISC, 7, 16, 0, 0, 5));
    send_cmd(make_cmd(OP_READ, 4, 0, 0, 0, 0));
    for (int op = OP_READ + 1; op <= OPC_LAST; op++)
      send_cmd(make_cmd(op, LAST_ROW, LAST_COL, LAST_ROW, LAST_COL, MAX_RADIUS));
    send_cmd(make_cmd(OP_DISC, LAST_ROW, LAST_COL, LAST_ROW, LAST_COL, MAX_RADIUS));
    send_cmd(make_cmd(OP_READ, 8, 0, 0, 0, 0));
  endtask

  task automatic test_random_traffic(int n_cmds);
    for (int k = 0; k < n_cmds; k++) begin
      if ($urandom_range(0, 9) == 0) gaps_on = ~gaps_on;
      send_cmd(random_cmd());
    end
  endtask

  task automatic test_back_to_back(int n_cmds);
    gaps_on = 1'b0;
    for (int k = 0; k < n_cmds; k++) send_cmd(random_cmd());
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL bitmap_shape_fill_engine");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    cmd_i          = '0;
    mismatch_count = 0;
    gaps_on        = 1'b1;
    for (int i = 0; i < ROWS; i++) bitmap_rows[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_traffic(700);
    test_back_to_back(250);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("PASS bitmap_shape_fill_engine");
    end else begin
      $display("FAIL bitmap_shape_fill_engine");
    end
    $finish;
  end

endmodule

/* bitmap_shape_fill_engine.f */
sv/bsfe_pkg.sv
sv/bsfe_ram.sv
sv/bsfe_row_mask.sv
sv/bitmap_shape_fill_engine.sv
test/bitmap_shape_fill_engine_tb.sv
